@@ rtl/core/rvds_pkg.sv @@
`default_nettype none
package rvds_pkg;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [31:0] NOP_WORD   = 32'h0000_0033;
    localparam logic [31:0] U_IMM_MASK = 32'hFFFF_F000;
    localparam logic [31:0] HALF_MASK  = 32'h0000_FFFF;
    localparam logic [31:0] BYTE_MASK  = 32'h0000_00FF;

    localparam logic [4:0] ALU_ADD        = 5'd0;
    localparam logic [4:0] ALU_SLL        = 5'd2;
    localparam logic [4:0] ALU_SLT        = 5'd3;
    localparam logic [4:0] ALU_SLT_U      = 5'd4;
    localparam logic [4:0] ALU_XOR        = 5'd5;
    localparam logic [4:0] ALU_SRL        = 5'd6;
    localparam logic [4:0] ALU_OR         = 5'd8;
    localparam logic [4:0] ALU_AND        = 5'd9;
    localparam logic [4:0] ALU_ADD_IMM    = 5'd10;
    localparam logic [4:0] ALU_SLT_IMM    = 5'd11;
    localparam logic [4:0] ALU_SLT_U_IMM  = 5'd12;
    localparam logic [4:0] ALU_XOR_IMM    = 5'd13;
    localparam logic [4:0] ALU_OR_IMM     = 5'd14;
    localparam logic [4:0] ALU_AND_IMM    = 5'd15;
    localparam logic [4:0] ALU_SLL_IMM    = 5'd16;
    localparam logic [4:0] ALU_SRL_IMM    = 5'd17;
    localparam logic [4:0] ALU_SRA_IMM    = 5'd18;
    localparam logic [4:0] ALU_ADD_PC_IMM = 5'd19;
    localparam logic [4:0] ALU_CMP_EQ     = 5'd20;

    localparam logic [3:0] MEM_ALU    = 4'd0;
    localparam logic [3:0] MEM_JUMP   = 4'd1;
    localparam logic [3:0] MEM_CJUMP  = 4'd2;
    localparam logic [3:0] MEM_W8     = 4'd3;
    localparam logic [3:0] MEM_R8S    = 4'd6;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_U,
        CLS_S,
        CLS_I,
        CLS_R
    } t_cls;

    typedef struct packed {
        logic        stall;
        logic [4:0]  alu_op;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] immediate;
        logic [31:0] pc;
        logic [3:0]  mem_op;
        logic        wb_op;
        logic [31:0] instr;
    } t_dec_res;

    function automatic t_cls op_class(input logic [31:0] w);
        t_cls c;
        case (w[6:0])
            OPC_LUI, OPC_AUIPC, OPC_JAL: c = CLS_U;
            OPC_BRANCH, OPC_STORE: c = CLS_S;
            OPC_LOAD, OPC_OPIMM, OPC_SYSTEM, OPC_JALR, OPC_FENCE: c = CLS_I;
            OPC_OP: c = CLS_R;
            default: c = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rvds_hazard.sv @@
`default_nettype none
module rvds_hazard (
    input  wire logic [31:0] i_instr,
    input  wire logic [31:0] i_exec_instr,
    input  wire logic [31:0] i_mem_instr,
    input  wire logic [31:0] i_wb_instr,
    output logic             o_hazard
);

    rvds_pkg::t_cls cls;
    logic [4:0]     rs1;
    logic [4:0]     rs2;
    logic [2:0]     hit;
    logic [31:0]    others [3];

    function automatic logic conflict(input logic [31:0] other, input logic [4:0] a,
                                      input logic [4:0] b, input rvds_pkg::t_cls c);
        rvds_pkg::t_cls oc;
        logic [4:0]     rd;
        oc = rvds_pkg::op_class(other);
        rd = other[11:7];
        if (oc == rvds_pkg::CLS_NONE || oc == rvds_pkg::CLS_S) begin
            return 1'b0;
        end
        return ((rd == a) && (a != 5'd0)) ||
               ((rd == b) && (c != rvds_pkg::CLS_I) && (b != 5'd0));
    endfunction

    assign cls       = rvds_pkg::op_class(i_instr);
    assign rs1       = i_instr[19:15];
    assign rs2       = i_instr[24:20];
    assign others[0] = i_exec_instr;
    assign others[1] = i_mem_instr;
    assign others[2] = i_wb_instr;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hit[k] = conflict(others[k], rs1, rs2, cls);
        end
    end

    assign o_hazard = (cls == rvds_pkg::CLS_S || cls == rvds_pkg::CLS_I ||
                       cls == rvds_pkg::CLS_R) && (|hit);

endmodule
`default_nettype wire

@@ rtl/core/rvds_decode.sv @@
`default_nettype none
module rvds_decode (
    input  wire logic [31:0]   i_instr,
    input  wire logic [31:0]   i_pc,
    input  wire logic [31:0]   i_rs1_value,
    input  wire logic [31:0]   i_rs2_value,
    input  wire logic          i_hazard,
    output rvds_pkg::t_dec_res o_res
);

    logic [2:0]  f3;
    logic        bit30;
    logic [31:0] iimm;
    logic [31:0] simm;
    logic [31:0] bimm;
    logic [31:0] jimm;
    logic [31:0] pc4;
    logic [31:0] sdata;
    logic [4:0]  imm_alu;
    logic [4:0]  reg_alu;

    assign f3    = i_instr[14:12];
    assign bit30 = i_instr[30];
    assign pc4   = i_pc + 32'd4;
    assign iimm  = {{20{i_instr[31]}}, i_instr[31:20]};
    assign simm  = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign bimm  = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8], 1'b0};
    assign jimm  = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21], 1'b0};

    always_comb begin
        case (f3)
            3'd0:    sdata = i_rs2_value & rvds_pkg::BYTE_MASK;
            3'd1:    sdata = i_rs2_value & rvds_pkg::HALF_MASK;
            default: sdata = i_rs2_value;
        endcase
    end

    always_comb begin
        case (f3)
            3'd0:    imm_alu = rvds_pkg::ALU_ADD_IMM;
            3'd1:    imm_alu = rvds_pkg::ALU_SLL_IMM;
            3'd2:    imm_alu = rvds_pkg::ALU_SLT_IMM;
            3'd3:    imm_alu = rvds_pkg::ALU_SLT_U_IMM;
            3'd4:    imm_alu = rvds_pkg::ALU_XOR_IMM;
            3'd5:    imm_alu = bit30 ? rvds_pkg::ALU_SRA_IMM : rvds_pkg::ALU_SRL_IMM;
            3'd6:    imm_alu = rvds_pkg::ALU_OR_IMM;
            default: imm_alu = rvds_pkg::ALU_AND_IMM;
        endcase
    end

    always_comb begin
        case (f3)
            3'd0:    reg_alu = rvds_pkg::ALU_ADD + {4'd0, bit30};
            3'd1:    reg_alu = rvds_pkg::ALU_SLL;
            3'd2:    reg_alu = rvds_pkg::ALU_SLT;
            3'd3:    reg_alu = rvds_pkg::ALU_SLT_U;
            3'd4:    reg_alu = rvds_pkg::ALU_XOR;
            3'd5:    reg_alu = rvds_pkg::ALU_SRL + {4'd0, bit30};
            3'd6:    reg_alu = rvds_pkg::ALU_OR;
            default: reg_alu = rvds_pkg::ALU_AND;
        endcase
    end

    always_comb begin
        // nop bubble unless a valid encoding below overrides
        o_res.stall     = 1'b0;
        o_res.alu_op    = rvds_pkg::ALU_ADD;
        o_res.operand_a = 32'd0;
        o_res.operand_b = 32'd0;
        o_res.immediate = 32'd0;
        o_res.pc        = 32'd0;
        o_res.mem_op    = rvds_pkg::MEM_ALU;
        o_res.wb_op     = 1'b1;
        o_res.instr     = i_instr;
        if (i_hazard) begin
            o_res.stall = 1'b1;
            o_res.wb_op = 1'b0;
            o_res.instr = rvds_pkg::NOP_WORD;
        end else begin
            case (i_instr[6:0])
                rvds_pkg::OPC_LUI: begin
                    o_res.alu_op    = rvds_pkg::ALU_ADD_IMM;
                    o_res.immediate = i_instr & rvds_pkg::U_IMM_MASK;
                    o_res.pc        = i_pc;
                end
                rvds_pkg::OPC_AUIPC: begin
                    o_res.alu_op    = rvds_pkg::ALU_ADD_PC_IMM;
                    o_res.immediate = i_instr & rvds_pkg::U_IMM_MASK;
                    o_res.pc        = i_pc;
                end
                rvds_pkg::OPC_JAL: begin
                    o_res.alu_op    = rvds_pkg::ALU_ADD_PC_IMM;
                    o_res.operand_b = pc4;
                    o_res.immediate = jimm;
                    o_res.pc        = i_pc;
                    o_res.mem_op    = rvds_pkg::MEM_JUMP;
                end
                rvds_pkg::OPC_BRANCH: begin
                    if (f3 != 3'd2 && f3 != 3'd3) begin
                        o_res.alu_op    = rvds_pkg::ALU_CMP_EQ +
                                          ((f3 < 3'd2) ? {2'd0, f3} : {2'd0, f3 - 3'd2});
                        o_res.operand_a = i_rs1_value;
                        o_res.operand_b = i_rs2_value;
                        o_res.immediate = bimm;
                        o_res.pc        = i_pc;
                        o_res.mem_op    = rvds_pkg::MEM_CJUMP;
                        o_res.wb_op     = 1'b0;
                    end
                end
                rvds_pkg::OPC_STORE: begin
                    if (f3 <= 3'd2) begin
                        o_res.alu_op    = rvds_pkg::ALU_ADD_IMM;
                        o_res.operand_a = i_rs1_value;
                        o_res.operand_b = sdata;
                        o_res.immediate = simm;
                        o_res.pc        = i_pc;
                        o_res.mem_op    = rvds_pkg::MEM_W8 + {1'b0, f3};
                        o_res.wb_op     = 1'b0;
                    end
                end
                rvds_pkg::OPC_LOAD: begin
                    if (f3 != 3'd3 && f3 <= 3'd5) begin
                        o_res.alu_op    = rvds_pkg::ALU_ADD_IMM;
                        o_res.operand_a = i_rs1_value;
                        o_res.immediate = iimm;
                        o_res.pc        = i_pc;
                        o_res.mem_op    = rvds_pkg::MEM_R8S +
                                          ((f3 < 3'd3) ? {1'b0, f3} : {1'b0, f3 - 3'd1});
                    end
                end
                rvds_pkg::OPC_OPIMM: begin
                    o_res.alu_op    = imm_alu;
                    o_res.operand_a = i_rs1_value;
                    o_res.immediate = iimm;
                    o_res.pc        = i_pc;
                end
                rvds_pkg::OPC_JALR: begin
                    o_res.alu_op    = rvds_pkg::ALU_ADD_IMM;
                    o_res.operand_a = i_rs1_value;
                    o_res.operand_b = pc4;
                    o_res.immediate = iimm;
                    o_res.pc        = i_pc;
                    o_res.mem_op    = rvds_pkg::MEM_JUMP;
                end
                rvds_pkg::OPC_OP: begin
                    o_res.alu_op    = reg_alu;
                    o_res.operand_a = i_rs1_value;
                    o_res.operand_b = i_rs2_value;
                    o_res.pc        = i_pc;
                end
                default: begin
                    o_res.wb_op = 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rv32i_decode_stage_with_hazard_stall.sv @@
// channel | valid      | ready      | payload
// in      | i_in_valid | o_in_ready | i_instr i_pc i_rs1_value i_rs2_value
//         |            |            | i_mem_stage_instr i_wb_stage_instr
// out     | o_out_valid| i_out_ready| o_stall_res o_alu_op o_operand_a o_operand_b
//         |            |            | o_immediate o_pc_out o_mem_op o_wb_op o_instr_out
//
// one transfer per cycle sustained while the output is not stalled
// input register, then decode and hazard check, then result register
// the execute-stage instruction is latched when an item moves into the result register
// reset clears both valid flags and the latched execute instruction
// a stalled output holds the result register; the input register refills behind it
`default_nettype none
module rv32i_decode_stage_with_hazard_stall (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_instr,
    input  wire logic [31:0] i_pc,
    input  wire logic [31:0] i_rs1_value,
    input  wire logic [31:0] i_rs2_value,
    input  wire logic [31:0] i_mem_stage_instr,
    input  wire logic [31:0] i_wb_stage_instr,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_stall_res,
    output logic [4:0]       o_alu_op,
    output logic [31:0]      o_operand_a,
    output logic [31:0]      o_operand_b,
    output logic signed [31:0] o_immediate,
    output logic [31:0]      o_pc_out,
    output logic [3:0]       o_mem_op,
    output logic             o_wb_op,
    output logic [31:0]      o_instr_out
);

    logic               r_in_valid;
    logic [31:0]        r_instr;
    logic [31:0]        r_pc;
    logic [31:0]        r_rs1_value;
    logic [31:0]        r_rs2_value;
    logic [31:0]        r_mem_instr;
    logic [31:0]        r_wb_instr;
    logic [31:0]        r_exec_instr;
    logic               r_out_valid;
    rvds_pkg::t_dec_res r_res;
    rvds_pkg::t_dec_res n_res;
    logic               hazard;
    logic               out_load;
    logic               in_load;

    rvds_hazard u_hazard (
        .i_instr      (r_instr),
        .i_exec_instr (r_exec_instr),
        .i_mem_instr  (r_mem_instr),
        .i_wb_instr   (r_wb_instr),
        .o_hazard     (hazard)
    );

    rvds_decode u_decode (
        .i_instr     (r_instr),
        .i_pc        (r_pc),
        .i_rs1_value (r_rs1_value),
        .i_rs2_value (r_rs2_value),
        .i_hazard    (hazard),
        .o_res       (n_res)
    );

    assign out_load   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || out_load;
    assign in_load    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_exec_instr <= 32'd0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_exec_instr <= n_res.instr;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_instr     <= i_instr;
            r_pc        <= i_pc;
            r_rs1_value <= i_rs1_value;
            r_rs2_value <= i_rs2_value;
            r_mem_instr <= i_mem_stage_instr;
            r_wb_instr  <= i_wb_stage_instr;
        end
        if (out_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_stall_res = r_res.stall;
    assign o_alu_op    = r_res.alu_op;
    assign o_operand_a = r_res.operand_a;
    assign o_operand_b = r_res.operand_b;
    assign o_immediate = r_res.immediate;
    assign o_pc_out    = r_res.pc;
    assign o_mem_op    = r_res.mem_op;
    assign o_wb_op     = r_res.wb_op;
    assign o_instr_out = r_res.instr;

endmodule
`default_nettype wire

@@ tb/sv/tb_rv32i_decode_stage_with_hazard_stall.sv @@
`default_nettype none
module tb_rv32i_decode_stage_with_hazard_stall;

    localparam int CYCLE_LIMIT = 500000;

    localparam logic [4:0] ALU_SUB      = 5'd1;
    localparam logic [4:0] ALU_SRA      = 5'd7;
    localparam logic [4:0] ALU_CMP_NEQ  = 5'd21;
    localparam logic [4:0] ALU_CMP_LT   = 5'd22;
    localparam logic [4:0] ALU_CMP_NLT  = 5'd23;
    localparam logic [4:0] ALU_CMP_LTU  = 5'd24;
    localparam logic [4:0] ALU_CMP_NLTU = 5'd25;

    localparam logic [3:0] MEM_W16  = 4'd4;
    localparam logic [3:0] MEM_W32  = 4'd5;
    localparam logic [3:0] MEM_R16S = 4'd7;
    localparam logic [3:0] MEM_R32  = 4'd8;
    localparam logic [3:0] MEM_R8U  = 4'd9;
    localparam logic [3:0] MEM_R16U = 4'd10;

    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_SLT   = 3'd2;
    localparam logic [2:0] F3_SLTU  = 3'd3;
    localparam logic [2:0] F3_XOR   = 3'd4;
    localparam logic [2:0] F3_SR    = 3'd5;
    localparam logic [2:0] F3_OR    = 3'd6;
    localparam logic [2:0] F3_AND   = 3'd7;
    localparam logic [2:0] F3_BEQ   = 3'd0;
    localparam logic [2:0] F3_BNE   = 3'd1;
    localparam logic [2:0] F3_BLT   = 3'd4;
    localparam logic [2:0] F3_BGE   = 3'd5;
    localparam logic [2:0] F3_BLTU  = 3'd6;
    localparam logic [2:0] F3_BGEU  = 3'd7;
    localparam logic [2:0] F3_SB    = 3'd0;
    localparam logic [2:0] F3_SH    = 3'd1;
    localparam logic [2:0] F3_SW    = 3'd2;
    localparam logic [2:0] F3_LB    = 3'd0;
    localparam logic [2:0] F3_LH    = 3'd1;
    localparam logic [2:0] F3_LW    = 3'd2;
    localparam logic [2:0] F3_LBU   = 3'd4;
    localparam logic [2:0] F3_LHU   = 3'd5;
    localparam logic [2:0] F3_CSRRS = 3'd2;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_instr = '0;
    logic [31:0] i_pc = '0;
    logic [31:0] i_rs1_value = '0;
    logic [31:0] i_rs2_value = '0;
    logic [31:0] i_mem_stage_instr = '0;
    logic [31:0] i_wb_stage_instr = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_stall_res;
    logic [4:0]  o_alu_op;
    logic [31:0] o_operand_a;
    logic [31:0] o_operand_b;
    logic signed [31:0] o_immediate;
    logic [31:0] o_pc_out;
    logic [3:0]  o_mem_op;
    logic        o_wb_op;
    logic [31:0] o_instr_out;

    rvds_pkg::t_dec_res decode_expect_q[$];
    logic [31:0] exec_latched = '0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit          tx_idle_en = 1'b0;
    t_rx_mode    rx_mode = RX_ALWAYS;
    bit          hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_len = 0;
    int          hold_left = 0;
    int          rx_cyc = 0;

    rv32i_decode_stage_with_hazard_stall i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_instr           (i_instr),
        .i_pc              (i_pc),
        .i_rs1_value       (i_rs1_value),
        .i_rs2_value       (i_rs2_value),
        .i_mem_stage_instr (i_mem_stage_instr),
        .i_wb_stage_instr  (i_wb_stage_instr),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_stall_res       (o_stall_res),
        .o_alu_op          (o_alu_op),
        .o_operand_a       (o_operand_a),
        .o_operand_b       (o_operand_b),
        .o_immediate       (o_immediate),
        .o_pc_out          (o_pc_out),
        .o_mem_op          (o_mem_op),
        .o_wb_op           (o_wb_op),
        .o_instr_out       (o_instr_out)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic rvds_pkg::t_cls opc_group(input logic [31:0] w);
        case (w[6:0])
            rvds_pkg::OPC_LUI, rvds_pkg::OPC_AUIPC, rvds_pkg::OPC_JAL:
                return rvds_pkg::CLS_U;
            rvds_pkg::OPC_BRANCH, rvds_pkg::OPC_STORE:
                return rvds_pkg::CLS_S;
            rvds_pkg::OPC_LOAD, rvds_pkg::OPC_OPIMM, rvds_pkg::OPC_SYSTEM,
            rvds_pkg::OPC_JALR, rvds_pkg::OPC_FENCE:
                return rvds_pkg::CLS_I;
            rvds_pkg::OPC_OP:
                return rvds_pkg::CLS_R;
            default:
                return rvds_pkg::CLS_NONE;
        endcase
    endfunction

    function automatic bit raw_clash(input logic [31:0] older, input logic [4:0] rs1,
                                     input logic [4:0] rs2, input rvds_pkg::t_cls cls);
        rvds_pkg::t_cls oc;
        logic [4:0]     rd;
        oc = opc_group(older);
        rd = older[11:7];
        if (oc == rvds_pkg::CLS_NONE || oc == rvds_pkg::CLS_S)
            return 1'b0;
        return (rd == rs1 && rs1 != 5'd0) ||
               (rd == rs2 && cls != rvds_pkg::CLS_I && rs2 != 5'd0);
    endfunction

    function automatic rvds_pkg::t_dec_res decode_and_latch(
        input logic [31:0] ins, input logic [31:0] pc,
        input logic [31:0] v1, input logic [31:0] v2,
        input logic [31:0] wm, input logic [31:0] ww);
        rvds_pkg::t_dec_res r;
        rvds_pkg::t_cls     cls;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [2:0]         f3;
        logic [31:0]        iimm;
        logic [31:0]        sdata;
        bit                 ok;
        rs1 = ins[19:15];
        rs2 = ins[24:20];
        f3 = ins[14:12];
        cls = opc_group(ins);
        iimm = {{20{ins[31]}}, ins[31:20]};
        ok = 1'b1;
        sdata = '0;
        r = '0;
        r.instr = ins;
        r.wb_op = 1'b1;
        if ((cls == rvds_pkg::CLS_S || cls == rvds_pkg::CLS_I || cls == rvds_pkg::CLS_R) &&
            (raw_clash(exec_latched, rs1, rs2, cls) || raw_clash(wm, rs1, rs2, cls) ||
             raw_clash(ww, rs1, rs2, cls))) begin
            exec_latched = rvds_pkg::NOP_WORD;
            r.stall = 1'b1;
            r.wb_op = 1'b0;
            r.instr = rvds_pkg::NOP_WORD;
            return r;
        end
        exec_latched = ins;
        case (ins[6:0])
            rvds_pkg::OPC_LUI, rvds_pkg::OPC_AUIPC: begin
                r.alu_op = (ins[6:0] == rvds_pkg::OPC_LUI) ? rvds_pkg::ALU_ADD_IMM
                                                           : rvds_pkg::ALU_ADD_PC_IMM;
                r.immediate = ins & rvds_pkg::U_IMM_MASK;
                r.pc = pc;
            end
            rvds_pkg::OPC_JAL: begin
                r.alu_op = rvds_pkg::ALU_ADD_PC_IMM;
                r.operand_b = pc + 32'd4;
                r.immediate = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                r.pc = pc;
                r.mem_op = rvds_pkg::MEM_JUMP;
            end
            rvds_pkg::OPC_BRANCH: begin
                case (f3)
                    F3_BEQ: r.alu_op = rvds_pkg::ALU_CMP_EQ;
                    F3_BNE: r.alu_op = ALU_CMP_NEQ;
                    F3_BLT: r.alu_op = ALU_CMP_LT;
                    F3_BGE: r.alu_op = ALU_CMP_NLT;
                    F3_BLTU: r.alu_op = ALU_CMP_LTU;
                    F3_BGEU: r.alu_op = ALU_CMP_NLTU;
                    default: ok = 1'b0;
                endcase
                if (ok) begin
                    r.operand_a = v1;
                    r.operand_b = v2;
                    r.immediate = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                    r.pc = pc;
                    r.mem_op = rvds_pkg::MEM_CJUMP;
                    r.wb_op = 1'b0;
                end
            end
            rvds_pkg::OPC_STORE: begin
                case (f3)
                    F3_SB: begin
                        sdata = v2 & rvds_pkg::BYTE_MASK;
                        r.mem_op = rvds_pkg::MEM_W8;
                    end
                    F3_SH: begin
                        sdata = v2 & rvds_pkg::HALF_MASK;
                        r.mem_op = MEM_W16;
                    end
                    F3_SW: begin
                        sdata = v2;
                        r.mem_op = MEM_W32;
                    end
                    default: ok = 1'b0;
                endcase
                if (ok) begin
                    r.alu_op = rvds_pkg::ALU_ADD_IMM;
                    r.operand_a = v1;
                    r.operand_b = sdata;
                    r.immediate = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    r.pc = pc;
                    r.wb_op = 1'b0;
                end
            end
            rvds_pkg::OPC_LOAD: begin
                case (f3)
                    F3_LB: r.mem_op = rvds_pkg::MEM_R8S;
                    F3_LH: r.mem_op = MEM_R16S;
                    F3_LW: r.mem_op = MEM_R32;
                    F3_LBU: r.mem_op = MEM_R8U;
                    F3_LHU: r.mem_op = MEM_R16U;
                    default: ok = 1'b0;
                endcase
                if (ok) begin
                    r.alu_op = rvds_pkg::ALU_ADD_IMM;
                    r.operand_a = v1;
                    r.immediate = iimm;
                    r.pc = pc;
                end
            end
            rvds_pkg::OPC_OPIMM: begin
                case (f3)
                    F3_ADD: r.alu_op = rvds_pkg::ALU_ADD_IMM;
                    F3_SLL: r.alu_op = rvds_pkg::ALU_SLL_IMM;
                    F3_SLT: r.alu_op = rvds_pkg::ALU_SLT_IMM;
                    F3_SLTU: r.alu_op = rvds_pkg::ALU_SLT_U_IMM;
                    F3_XOR: r.alu_op = rvds_pkg::ALU_XOR_IMM;
                    F3_SR: r.alu_op = ins[30] ? rvds_pkg::ALU_SRA_IMM : rvds_pkg::ALU_SRL_IMM;
                    F3_OR: r.alu_op = rvds_pkg::ALU_OR_IMM;
                    default: r.alu_op = rvds_pkg::ALU_AND_IMM;
                endcase
                r.operand_a = v1;
                r.immediate = iimm;
                r.pc = pc;
            end
            rvds_pkg::OPC_JALR: begin
                r.alu_op = rvds_pkg::ALU_ADD_IMM;
                r.operand_a = v1;
                r.operand_b = pc + 32'd4;
                r.immediate = iimm;
                r.pc = pc;
                r.mem_op = rvds_pkg::MEM_JUMP;
            end
            rvds_pkg::OPC_OP: begin
                case (f3)
                    F3_ADD: r.alu_op = ins[30] ? ALU_SUB : rvds_pkg::ALU_ADD;
                    F3_SLL: r.alu_op = rvds_pkg::ALU_SLL;
                    F3_SLT: r.alu_op = rvds_pkg::ALU_SLT;
                    F3_SLTU: r.alu_op = rvds_pkg::ALU_SLT_U;
                    F3_XOR: r.alu_op = rvds_pkg::ALU_XOR;
                    F3_SR: r.alu_op = ins[30] ? ALU_SRA : rvds_pkg::ALU_SRL;
                    F3_OR: r.alu_op = rvds_pkg::ALU_OR;
                    default: r.alu_op = rvds_pkg::ALU_AND;
                endcase
                r.operand_a = v1;
                r.operand_b = v2;
                r.pc = pc;
            end
            default: ;
        endcase
        return r;
    endfunction

    // random word, mostly legal opcodes; near keeps register fields in x0..x3
    function automatic logic [31:0] rand_instr(input bit near);
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 13))
            0: w[6:0] = rvds_pkg::OPC_LUI;
            1: w[6:0] = rvds_pkg::OPC_AUIPC;
            2: w[6:0] = rvds_pkg::OPC_JAL;
            3: w[6:0] = rvds_pkg::OPC_BRANCH;
            4: w[6:0] = rvds_pkg::OPC_STORE;
            5: w[6:0] = rvds_pkg::OPC_LOAD;
            6, 7: w[6:0] = rvds_pkg::OPC_OPIMM;
            8: w[6:0] = rvds_pkg::OPC_SYSTEM;
            9: w[6:0] = rvds_pkg::OPC_JALR;
            10: w[6:0] = rvds_pkg::OPC_FENCE;
            11, 12: w[6:0] = rvds_pkg::OPC_OP;
            default: ;
        endcase
        if (near) begin
            w[11:7] = 5'($urandom_range(0, 3));
            w[19:15] = 5'($urandom_range(0, 3));
            w[24:20] = 5'($urandom_range(0, 3));
        end
        return w;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(negedge i_clk) begin
        rvds_pkg::t_dec_res want_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decode_expect_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual instr %h",
                         $time, o_instr_out);
                mismatch_cnt++;
            end else begin
                want_res = decode_expect_q.pop_front();
                check_field("stall_res", o_stall_res, want_res.stall);
                check_field("alu_op", o_alu_op, want_res.alu_op);
                check_field("operand_a", o_operand_a, want_res.operand_a);
                check_field("operand_b", o_operand_b, want_res.operand_b);
                check_field("immediate", o_immediate, want_res.immediate);
                check_field("pc_out", o_pc_out, want_res.pc);
                check_field("mem_op", o_mem_op, want_res.mem_op);
                check_field("wb_op", o_wb_op, want_res.wb_op);
                check_field("instr_out", o_instr_out, want_res.instr);
            end
        end
    end

    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= hold_len;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ((rx_cyc % 9) < 5);
            endcase
        end
    end

    task automatic send_item(input logic [31:0] ins, input logic [31:0] pc,
                             input logic [31:0] v1, input logic [31:0] v2,
                             input logic [31:0] wm, input logic [31:0] ww);
        int gap;
        bit took;
        if (tx_idle_en) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 5);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_instr <= ins;
        i_pc <= pc;
        i_rs1_value <= v1;
        i_rs2_value <= v2;
        i_mem_stage_instr <= wm;
        i_wb_stage_instr <= ww;
        i_in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        decode_expect_q.push_back(decode_and_latch(ins, pc, v1, v2, wm, ww));
    endtask

    task automatic send_random();
        bit          near;
        logic [31:0] wm;
        logic [31:0] ww;
        near = ($urandom_range(0, 2) == 0);
        wm = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_instr(near);
        ww = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_instr(near);
        send_item(rand_instr(near), $urandom, $urandom, $urandom, wm, ww);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (decode_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic start_hold(input int len);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        hold_len = len;
        hold_req = ~hold_req;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [2:0]  f3;
        logic [31:0] add_x5;
        logic [31:0] add_x6;
        tx_idle_en = 1'b0;
        rx_mode = RX_ALWAYS;
        add_x5 = {12'h001, 5'd0, F3_ADD, 5'd5, rvds_pkg::OPC_OPIMM};
        add_x6 = {7'h00, 5'd0, 5'd5, F3_ADD, 5'd6, rvds_pkg::OPC_OP};
        send_item({20'hFFFFF, 5'd1, rvds_pkg::OPC_LUI}, 32'h0, '1, '1, '0, '0);
        send_item({20'h80000, 5'd2, rvds_pkg::OPC_AUIPC}, '1, '0, '0, '0, '0);
        send_item({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd3, rvds_pkg::OPC_JAL}, 32'hFFFF_FFFC,
                  '1, '1, '0, '0);
        send_item({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, rvds_pkg::OPC_JAL}, 32'h0,
                  '0, '0, '0, '0);
        send_item({12'h800, 5'd31, F3_ADD, 5'd31, rvds_pkg::OPC_JALR}, 32'hFFFF_FFFC,
                  '1, '0, '0, '0);
        // all branch compares plus the two undefined branch funct3 values
        for (int k = 0; k < 8; k++) begin
            f3 = k[2:0];
            send_item({f3[0] ? 7'h7F : 7'h40, 5'd9, 5'd8, f3, f3[0] ? 5'h1F : 5'h01,
                       rvds_pkg::OPC_BRANCH},
                      $urandom, $urandom, $urandom, '0, '0);
        end
        for (int k = 0; k < 3; k++) begin
            f3 = k[2:0];
            send_item({7'h7F, 5'd9, 5'd8, f3, 5'h1F, rvds_pkg::OPC_STORE}, $urandom,
                      '1, '1, '0, '0);
        end
        send_item({12'hFFF, 5'd8, F3_LB, 5'd10, rvds_pkg::OPC_LOAD}, $urandom,
                  '1, '1, '0, '0);
        // only bit 30 of funct7 is looked at
        send_item({7'h60, 5'd31, 5'd12, F3_SR, 5'd11, rvds_pkg::OPC_OPIMM}, $urandom,
                  '1, '0, '0, '0);
        send_item({7'h7F, 5'd13, 5'd14, F3_ADD, 5'd12, rvds_pkg::OPC_OP}, $urandom,
                  '0, '1, '0, '0);
        send_item(32'h0000_0073, $urandom, $urandom, $urandom, '0, '0);
        send_item(32'h0010_0073, $urandom, $urandom, $urandom, '0, '0);
        send_item({12'h300, 5'd1, F3_CSRRS, 5'd5, rvds_pkg::OPC_SYSTEM}, $urandom,
                  '1, '1, '0, '0);
        send_item(32'h0FF0_000F, $urandom, $urandom, $urandom, '0, '0);
        send_item(32'hFFFF_FFFF, '1, '1, '1, '1, '1);
        // hazards through execute, memory and writeback stages
        send_item(add_x5, $urandom, $urandom, $urandom, '0, '0);
        send_item(add_x6, $urandom, $urandom, $urandom, '0, '0);
        send_item(add_x6, $urandom, $urandom, $urandom, add_x5, '0);
        send_item({7'h00, 5'd5, 5'd0, F3_ADD, 5'd7, rvds_pkg::OPC_OPIMM}, $urandom,
                  '1, '1, '0, add_x5);
        send_item({7'h00, 5'd5, 5'd0, F3_SW, 5'd0, rvds_pkg::OPC_STORE}, $urandom,
                  '1, '1, '0, add_x5);
        drain_results();
    endtask

    task automatic test_random_flow();
        for (int n = 0; n < 1200; n++) begin
            if (n % 200 == 0) begin
                rx_mode = (n == 0) ? RX_ALWAYS : t_rx_mode'($urandom_range(0, 3));
                tx_idle_en = (n != 0) && ($urandom_range(0, 3) != 0);
            end
            send_random();
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        tx_idle_en = 1'b0;
        for (int n = 0; n < 640; n++) begin
            if (n % 160 == 0)
                start_hold($urandom_range(40, 80));
            send_random();
        end
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_flow();
        test_backpressure();
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
